// ===== hw/rtl/md5_chained_random_bits_macros.svh =====
// assertion macros shared by the rtl
`ifndef MD5_CHAINED_RANDOM_BITS_MACROS_SVH
`define MD5_CHAINED_RANDOM_BITS_MACROS_SVH

// implication checked every clock, quiet during reset
`define MCRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked every clock, quiet during reset
`define MCRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/mcrb_pkg.sv =====
package mcrb_pkg;

	localparam int unsigned MAX_BITS_DEF = 24;

	// round constants
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
				6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
				6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
				6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
				6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
				6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
				6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
				6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
				6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
				6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
				6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
				6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
				6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
				6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
				6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
				6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
				6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
				6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
				6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
				6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
				6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
				default: k = 32'heb86d391;
			endcase
			return k;
		end
	endfunction

	// rotate amounts
	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		begin
			case ({i[5:4], i[1:0]})
				4'd0: s = 5'd7; 4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
				4'd4: s = 5'd5; 4'd5: s = 5'd9; 4'd6: s = 5'd14; 4'd7: s = 5'd20;
				4'd8: s = 5'd4; 4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15;
				default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

endpackage

// ===== hw/rtl/mcrb_md5_core.sv =====
`include "md5_chained_random_bits_macros.svh"

// one md5 round per cycle over a 24-byte message padded into one 64-byte block
module mcrb_md5_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   seed,
	input  logic [31:0]   serial,
	input  logic [127:0]  prev,
	output logic          done,
	output logic [127:0]  digest
);
	import mcrb_pkg::*;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	logic        busy_q;
	logic [5:0]  round_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f, mw, sum, rot;
	logic [3:0]  g;
	logic [4:0]  s;

	// message word select
	always_comb begin
		case (round_q[5:4])
			2'd0: g = round_q[3:0];
			2'd1: g = 4'(5 * round_q[3:0] + 1);
			2'd2: g = 4'(3 * round_q[3:0] + 5);
			default: g = 4'(7 * round_q[3:0]);
		endcase
		case (g)
			4'd0: mw = seed;
			4'd1: mw = serial;
			4'd2: mw = prev[31:0];
			4'd3: mw = prev[63:32];
			4'd4: mw = prev[95:64];
			4'd5: mw = prev[127:96];
			4'd6: mw = 32'h00000080;
			4'd14: mw = 32'd192;
			default: mw = 32'd0;
		endcase
	end

	// round function and rotate
	always_comb begin
		case (round_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		s   = md5_s(round_q);
		sum = a_q + f + md5_k(round_q) + mw;
		rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start && !busy_q) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// working state
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= IV_A; b_q <= IV_B; c_q <= IV_C; d_q <= IV_D;
		end else if (busy_q) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
		end
	end

	assign digest = {d_q + IV_D, c_q + IV_C, b_q + IV_B, a_q + IV_A};

	`MCRB_ASSERT_NXT(a_done_ends, clk, arst_n, done, !busy_q)
	`MCRB_ASSERT_IMP(a_done_idle, clk, arst_n, done, round_q == 6'd0)
	`MCRB_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy_q, busy_q)

endmodule

// ===== hw/rtl/md5_chained_random_bits.sv =====
// md5 hash-chain random generator. A transaction on the input channel asks for
// func 0 (request_size low bits, at most MAX_BITS) or func 1 (a value below
// request_size); one value comes back per transaction. The bit reservoir takes
// one pool byte per cycle while the pool holds bytes; when the 16-byte pool
// runs dry, one md5 refill runs on the round unit while the fill waits. An
// item passes through the fill with any refills, then for func 1 a multiply
// step, then the output state. The block accepts no item while one is in work
// or its result waits. The user must write seed through the cfg channel only
// while the block is idle; the block itself does not enforce it.
`include "md5_chained_random_bits_macros.svh"

module md5_chained_random_bits #(
	parameter int unsigned MAX_BITS = mcrb_pkg::MAX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] request_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import mcrb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_HASH = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [5:0] MAXB    = 6'(MAX_BITS);

	logic [2:0]   state_q;
	logic [31:0]  seed_q, serial_q, res_q;
	logic [127:0] pool_q;
	logic [4:0]   ptr_q;
	logic [5:0]   cnt_q, need_q;
	logic         func_q;
	logic [31:0]  req_q, value_q;
	logic         hash_start_q;
	logic         hash_done;
	logic [127:0] hash_digest;
	logic [31:0]  drawn;
	logic [55:0]  prod;
	logic [7:0]   pool_byte;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign value     = value_q;

	assign pool_byte = pool_q[{ptr_q[3:0], 3'b000} +: 8];
	assign drawn     = res_q & ((32'd1 << need_q) - 32'd1);
	assign prod      = 56'(value_q[MAX_BITS-1:0]) * 56'(req_q);

	mcrb_md5_core u_core (
		.clk(clk), .arst_n(arst_n), .start(hash_start_q), .seed(seed_q),
		.serial(serial_q), .prev(pool_q), .done(hash_done), .digest(hash_digest)
	);

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_valid && cfg_ready) seed_q <= cfg_data;
	end

	// sequencer: fill reservoir a byte at a time, refill pool on demand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			serial_q     <= '0;
			pool_q       <= '0;
			ptr_q        <= 5'd16;
			res_q        <= '0;
			cnt_q        <= '0;
			need_q       <= '0;
			func_q       <= 1'b0;
			req_q        <= '0;
			value_q      <= '0;
			hash_start_q <= 1'b0;
		end else begin
			hash_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						req_q  <= request_size;
						if (func) need_q <= MAXB;
						else if (request_size > 32'(MAX_BITS)) need_q <= MAXB;
						else need_q <= request_size[5:0];
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (cnt_q < need_q) begin
						if (ptr_q[4]) begin
							hash_start_q <= 1'b1;
							state_q      <= ST_HASH;
						end else begin
							res_q <= res_q | (32'(pool_byte) << cnt_q[4:0]);
							ptr_q <= ptr_q + 5'd1;
							cnt_q <= cnt_q + 6'd8;
						end
					end else begin
						res_q   <= res_q >> need_q;
						cnt_q   <= cnt_q - need_q;
						value_q <= drawn;
						state_q <= func_q ? ST_MUL : ST_OUT;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						pool_q   <= hash_digest;
						serial_q <= serial_q + 32'd1;
						ptr_q    <= '0;
						state_q  <= ST_FILL;
					end
				end
				ST_MUL: begin
					value_q <= 32'(prod[55:MAX_BITS]);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// note: ST_MUL uses req_q and drawn from value_q path
	`MCRB_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 6'd31)
	`MCRB_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, ptr_q <= 5'd16)
	`MCRB_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(value))

endmodule
